### rtl/core/ehp_pkg.sv
// ehp_pkg: types and constants shared by the Ethernet/IPv4/L4 header parser.
// No dependencies.
package ehp_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FIFO_DEPTH      = 2;

  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_NUM_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_NUM_UDP  = 8'd17;
  localparam logic [3:0]  UDP_HEADER_LEN = 4'd8;

  // frame byte positions
  localparam logic [15:0] OFF_SRC_MAC  = 16'd6;
  localparam logic [15:0] OFF_ETYPE    = 16'd12;
  localparam logic [15:0] OFF_IHL      = 16'd14;
  localparam logic [15:0] OFF_TOTAL_HI = 16'd16;
  localparam logic [15:0] OFF_TOTAL_LO = 16'd17;
  localparam logic [15:0] OFF_PROTO    = 16'd23;
  localparam logic [15:0] OFF_IP_ADDR  = 16'd26;
  localparam logic [15:0] OFF_IP_END   = 16'd34;
  localparam logic [15:0] OFF_MAX      = 16'hFFFF;
  localparam logic [6:0]  ETH_HDR_BYTES = 7'd14;

  // layer 4 relative positions
  localparam logic [15:0] REL_PORTS_END = 16'd4;
  localparam logic [15:0] REL_TCP_OFF   = 16'd12;
  localparam logic [15:0] REL_CHK_HI    = 16'd16;
  localparam logic [15:0] REL_CHK_LO    = 16'd17;

  localparam logic [1:0] CLASS_TCP   = 2'd0;
  localparam logic [1:0] CLASS_UDP   = 2'd1;
  localparam logic [1:0] CLASS_IP    = 2'd2;
  localparam logic [1:0] CLASS_NONIP = 2'd3;

  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_kind;
    logic [3:0]  ihl;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [63:0] ip_addr;   // src high, dst low
    logic [31:0] ports;     // src high, dst low
    logic [3:0]  tcp_off;
    logic [15:0] tcp_chk;
  } hdr_rec_t;

endpackage

### rtl/core/ehp_if.sv
// ehp_if: valid/ready channel interfaces for frame bytes and parse results.
// No dependencies.
interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ehp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_class;
  logic [47:0]        dst_mac;
  logic [47:0]        src_mac;
  logic [31:0]        src_ip;
  logic [31:0]        dst_ip;
  logic [15:0]        src_port;
  logic [15:0]        dst_port;
  logic [15:0]        tcp_checksum;
  logic signed [16:0] payload_size;
  logic [31:0]        ip_count;
  logic [31:0]        tcp_count;
  logic [31:0]        udp_count;

  modport source (output valid, frame_class, dst_mac, src_mac, src_ip, dst_ip, src_port,
                  dst_port, tcp_checksum, payload_size, ip_count, tcp_count, udp_count,
                  input ready);
  modport sink   (input valid, frame_class, dst_mac, src_mac, src_ip, dst_ip, src_port,
                  dst_port, tcp_checksum, payload_size, ip_count, tcp_count, udp_count,
                  output ready);
endinterface

### rtl/core/ehp_front.sv
// ehp_front: byte offset tracking and header field capture, one byte per cycle while the queue can accept a record.
// Depends on ehp_pkg and ehp_in_if.
module ehp_front import ehp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  ehp_in_if.sink   frame,
  output hdr_rec_t rec,
  output logic     rec_valid,
  input  logic     rec_ready
);

  logic [15:0] off;
  hdr_rec_t    cap;
  hdr_rec_t    cap_next;
  logic [7:0]  b;
  logic [3:0]  src_lane;
  logic [5:0]  ip_lane;
  logic [6:0]  base;
  logic [15:0] rel;
  logic        take;

  assign frame.ready = rec_ready;
  assign take        = frame.valid & rec_ready;
  assign b           = frame.data_byte;
  assign src_lane    = 4'd11 - off[3:0];
  assign ip_lane     = 6'd33 - off[5:0];

  always_comb begin
    cap_next = cap;
    priority if (off < OFF_SRC_MAC) begin
      cap_next.dst_mac[{3'd5 - off[2:0], 3'b000} +: 8] = b;
    end else if (off < OFF_ETYPE) begin
      cap_next.src_mac[{src_lane[2:0], 3'b000} +: 8] = b;
    end else if (off < OFF_IHL) begin
      cap_next.ether_kind[{~off[0], 3'b000} +: 8] = b;
    end else if (off == OFF_IHL) begin
      cap_next.ihl = b[3:0];
    end else if (off == OFF_TOTAL_HI || off == OFF_TOTAL_LO) begin
      cap_next.total_len[{~off[0], 3'b000} +: 8] = b;
    end else if (off == OFF_PROTO) begin
      cap_next.proto = b;
    end else if (off >= OFF_IP_ADDR && off < OFF_IP_END) begin
      cap_next.ip_addr[{ip_lane[2:0], 3'b000} +: 8] = b;
    end else begin
      cap_next = cap;
    end

    // layer 4 header starts at 14 + 4*IHL, IHL as updated by this byte
    base = ETH_HDR_BYTES + {1'b0, cap_next.ihl, 2'b00};
    rel  = off - {9'd0, base};
    if (off >= {9'd0, base}) begin
      priority if (rel < REL_PORTS_END) begin
        cap_next.ports[{~rel[1:0], 3'b000} +: 8] = b;
      end else if (rel == REL_TCP_OFF) begin
        cap_next.tcp_off = b[7:4];
      end else if (rel == REL_CHK_HI || rel == REL_CHK_LO) begin
        cap_next.tcp_chk[{~rel[0], 3'b000} +: 8] = b;
      end else begin
        cap_next.tcp_off = cap_next.tcp_off;
      end
    end
  end

  assign rec       = cap_next;
  assign rec_valid = frame.valid & frame.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      off <= '0;
      cap <= '0;
    end else if (take) begin
      if (frame.last_byte) begin
        off <= '0;
        cap <= '0;
      end else begin
        if (off != OFF_MAX) off <= off + 16'd1;
        cap <= cap_next;
      end
    end
  end

endmodule

### rtl/core/ehp_fifo.sv
// ehp_fifo: short queue of captured header records between front and back.
// Depends on ehp_pkg.
module ehp_fifo import ehp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  hdr_rec_t push_rec,
  input  logic     push_valid,
  output logic     push_ready,
  output hdr_rec_t pop_rec,
  output logic     pop_valid,
  input  logic     pop_ready
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  hdr_rec_t         mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_rec    = mem[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/ehp_back.sv
// ehp_back: frame classification, payload size, packet counters, output register.
// Depends on ehp_pkg and ehp_out_if.
module ehp_back import ehp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  hdr_rec_t rec,
  input  logic     rec_valid,
  output logic     rec_ready,
  ehp_out_if.source result
);

  logic [COUNT_WIDTH-1:0] ip_cnt, tcp_cnt, udp_cnt;
  logic [COUNT_WIDTH-1:0] ip_cnt_next, tcp_cnt_next, udp_cnt_next;
  logic                   out_valid;
  logic                   pop;
  logic [1:0]             cls;
  logic signed [16:0]     rest;
  logic signed [16:0]     payload;
  logic                   is_ip;

  assign pop       = rec_valid & (~out_valid | result.ready);
  assign rec_ready = ~out_valid | result.ready;
  assign result.valid = out_valid;

  always_comb begin
    is_ip        = (rec.ether_kind == ETYPE_IPV4);
    rest         = $signed({1'b0, rec.total_len}) - $signed({11'd0, rec.ihl, 2'b00});
    cls          = CLASS_NONIP;
    payload      = '0;
    ip_cnt_next  = ip_cnt;
    tcp_cnt_next = tcp_cnt;
    udp_cnt_next = udp_cnt;
    if (is_ip) begin
      ip_cnt_next = ip_cnt + 1'b1;
      priority if (rec.proto == PROTO_NUM_TCP) begin
        cls          = CLASS_TCP;
        payload      = rest - $signed({11'd0, rec.tcp_off, 2'b00});
        tcp_cnt_next = tcp_cnt + 1'b1;
      end else if (rec.proto == PROTO_NUM_UDP) begin
        cls          = CLASS_UDP;
        payload      = rest - $signed({13'd0, UDP_HEADER_LEN});
        udp_cnt_next = udp_cnt + 1'b1;
      end else begin
        cls     = CLASS_IP;
        payload = rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ip_cnt    <= '0;
      tcp_cnt   <= '0;
      udp_cnt   <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        ip_cnt    <= ip_cnt_next;
        tcp_cnt   <= tcp_cnt_next;
        udp_cnt   <= udp_cnt_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.frame_class  <= cls;
      result.dst_mac      <= rec.dst_mac;
      result.src_mac      <= rec.src_mac;
      result.src_ip       <= is_ip ? rec.ip_addr[63:32] : 32'd0;
      result.dst_ip       <= is_ip ? rec.ip_addr[31:0] : 32'd0;
      result.src_port     <= (cls == CLASS_TCP || cls == CLASS_UDP) ? rec.ports[31:16] : 16'd0;
      result.dst_port     <= (cls == CLASS_TCP || cls == CLASS_UDP) ? rec.ports[15:0] : 16'd0;
      result.tcp_checksum <= (cls == CLASS_TCP) ? rec.tcp_chk : 16'd0;
      result.payload_size <= payload;
      result.ip_count     <= 32'(ip_cnt_next);
      result.tcp_count    <= 32'(tcp_cnt_next);
      result.udp_count    <= 32'(udp_cnt_next);
    end
  end

endmodule

### rtl/core/eth_ipv4_l4_header_parser.sv
// eth_ipv4_l4_header_parser: top level of the Ethernet/IPv4/TCP/UDP header parser.
// Depends on ehp_pkg, ehp_if, ehp_front, ehp_fifo, ehp_back.
//
// Usage:
//   frame  - input channel, one frame byte per item, starting at the destination
//            MAC; last_byte marks the final byte of the frame.
//   result - output channel, one item per frame: class, MACs, IPs, ports,
//            TCP checksum, payload size and running IP/TCP/UDP counts.
// Throughput: one byte per cycle, sustained while result is ready, including back-to-back
//   one-byte frames; the front captures a byte per cycle while the queue has room and the
//   back retires one frame record per cycle while result is ready.
// Path: after its last byte is accepted, the frame record is registered in the
//   queue and then in the output register, where the result item becomes valid.
// Stall: while result is stalled, up to two more frame records are held in
//   the queue between front and back; frame.ready drops only when that
//   queue is full.
// Reset: synchronous, clears the byte offset, captured fields, queue,
//   output valid and the packet counters; no clearing pass.
module eth_ipv4_l4_header_parser import ehp_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ehp_in_if.sink    frame,
  ehp_out_if.source result
);

  hdr_rec_t front_rec;
  logic     front_valid;
  logic     front_ready;
  hdr_rec_t back_rec;
  logic     back_valid;
  logic     back_ready;

  ehp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .rec       (front_rec),
    .rec_valid (front_valid),
    .rec_ready (front_ready)
  );

  ehp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_rec   (front_rec),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_rec    (back_rec),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  ehp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (back_rec),
    .rec_valid (back_valid),
    .rec_ready (back_ready),
    .result    (result)
  );

endmodule
